>>> sv/hssrd_pkg.sv
package hssrd_pkg;

    // request kinds carried in tuser
    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_BURST  = 2'd1;
    localparam logic [1:0] REQ_LOAD   = 2'd2;

    // field widths fixed by the stream format
    localparam int TS_W    = 32;
    localparam int CNT_W   = 5;
    localparam int SPEED_W = 16;
    localparam int COIL_W  = 4;
    localparam int PHASE_W = 3;

    // speed is kept inside +/- this limit
    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sd32767;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = -16'sd32767;

    typedef logic [PHASE_W-1:0] t_phase;
    typedef logic [COIL_W-1:0]  t_coil;

    // divider hand-off back to the sequencer
    typedef struct packed {
        logic done;
        logic busy;
    } t_div_stat;

    // half-step coil table, bit3 first coil through bit0 fourth coil
    function automatic t_coil coil_of(input t_phase p);
        t_coil c;
        unique case (p)
            3'd0: c = 4'h1;
            3'd1: c = 4'h3;
            3'd2: c = 4'h2;
            3'd3: c = 4'h6;
            3'd4: c = 4'h4;
            3'd5: c = 4'hC;
            3'd6: c = 4'h8;
            3'd7: c = 4'h9;
            default: c = 4'h1;
        endcase
        return c;
    endfunction

endpackage

>>> sv/hssrd_div.sv
module hssrd_div
    import hssrd_pkg::*;
#(
    parameter int NUMERATOR = 256000
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [SPEED_W-1:0]                i_den,
    output t_div_stat                         o_stat,
    output logic [$clog2(NUMERATOR+1)-1:0]    o_quot
);

    localparam int Q_W = $clog2(NUMERATOR + 1);
    localparam int C_W = $clog2(Q_W + 1);
    localparam logic [Q_W-1:0] NUM_BITS = Q_W'(NUMERATOR);

    logic               r_busy;
    logic               r_done;
    logic [C_W-1:0]     r_cnt;
    logic [Q_W-1:0]     r_num;
    logic [SPEED_W-1:0] r_rem;
    logic [SPEED_W-1:0] r_den;

    logic [SPEED_W:0]   w_trial;
    logic               w_fits;

    // shift in the next numerator bit and try a subtract
    assign w_trial = {r_rem, r_num[Q_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_den});

    // control: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= C_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == C_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: restoring division, quotient bits replace numerator bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NUM_BITS;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[Q_W-2:0], w_fits};
            r_rem <= w_fits ? SPEED_W'(w_trial - {1'b0, r_den}) : SPEED_W'(w_trial);
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.busy = r_busy;
    assign o_quot      = r_num;

endmodule

>>> sv/halfstep_stepper_ramp_driver.sv
// Half-step sequencer for a four-coil unipolar stepper with a speed ramp. Requests come in on
// the slave stream with the kind in tuser: a timed update (timestamp in tdata) emits at most one
// coil pattern, when the speed is nonzero and the time since the last step has reached
// INTERVAL_NUMERATOR/(|speed|+1), and then adds the acceleration register to the speed with
// saturation at +/-32767; a burst emits min(step_count, MAX_BURST) patterns back to back; a
// load sets the speed. The phase moves up after a pattern for positive speed and down
// otherwise. A timed update with nonzero speed goes through the bit-serial interval divider
// and then a compare state; a burst emits one pattern per cycle when the master side does not
// stall. The block takes one request at a time. The acceleration register may be written at
// any cycle but should only change while the block is idle.
module halfstep_stepper_ramp_driver
    import hssrd_pkg::*;
#(
    parameter int MAX_BURST          = 16,
    parameter int INTERVAL_NUMERATOR = 256000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [55:0]        s_axis_tdata,   // timestamp_us[31:0], step_count[36:32],
                                               // speed_value[52:37], zero fill
    input  logic [1:0]         s_axis_tuser,   // req_type[1:0]
    // coil pattern stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // coil_pattern[3:0], phase_index[6:4], zero fill
    output logic               m_axis_tlast,   // last_of_run
    // acceleration register write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SPEED_W-1:0] i_cfg_data
);

    localparam int Q_W = $clog2(INTERVAL_NUMERATOR + 1);
    localparam int BURST_CAP = (MAX_BURST < 31) ? MAX_BURST : 31;

    // speed limits at the width of the ramp sum
    localparam logic signed [SPEED_W:0] SUM_MAX = (SPEED_W+1)'(SPEED_MAX);
    localparam logic signed [SPEED_W:0] SUM_MIN = (SPEED_W+1)'(SPEED_MIN);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_BURST = 2'd3;

    logic [1:0]                r_state;
    t_phase                    r_phase;
    logic signed [SPEED_W-1:0] r_vel;
    logic signed [SPEED_W-1:0] r_acc;
    logic [TS_W-1:0]           r_last_ts;
    logic [TS_W-1:0]           r_ts;
    logic [TS_W-1:0]           r_elapsed;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_ovalid;
    t_coil                     r_ocoil;
    t_phase                    r_ophase;
    logic                      r_olast;

    logic                      w_accept;
    logic [1:0]                w_req;
    logic [TS_W-1:0]           w_ts;
    logic [CNT_W-1:0]          w_step_count;
    logic signed [SPEED_W-1:0] w_speed;
    logic [SPEED_W-1:0]        w_mag;
    logic [SPEED_W-1:0]        w_den;
    logic signed [SPEED_W:0]   w_sum;
    logic signed [SPEED_W-1:0] w_ramped;
    logic [CNT_W-1:0]          w_burst_n;
    logic                      w_out_free;
    logic                      w_due;
    t_phase                    w_next_phase;
    logic                      w_div_start;
    t_div_stat                 w_div_stat;
    logic [Q_W-1:0]            w_quot;

    // unpack the request word
    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_req        = s_axis_tuser;
    assign w_ts         = s_axis_tdata[31:0];
    assign w_step_count = s_axis_tdata[36:32];
    assign w_speed      = s_axis_tdata[52:37];

    // speed magnitude and divisor (speed never reaches -32768)
    assign w_mag = r_vel[SPEED_W-1] ? SPEED_W'(-r_vel) : r_vel;
    assign w_den = w_mag + 1'b1;

    // ramped speed with saturation
    assign w_sum = {r_vel[SPEED_W-1], r_vel} + {r_acc[SPEED_W-1], r_acc};
    always_comb begin
        priority if (w_sum > SUM_MAX) begin
            w_ramped = SPEED_MAX;
        end else if (w_sum < SUM_MIN) begin
            w_ramped = SPEED_MIN;
        end else begin
            w_ramped = w_sum[SPEED_W-1:0];
        end
    end

    // burst length cap
    assign w_burst_n = (32'(w_step_count) > 32'(BURST_CAP)) ? CNT_W'(BURST_CAP) : w_step_count;

    // step due check and phase direction
    assign w_due        = (r_elapsed >= TS_W'(w_quot));
    assign w_out_free   = !r_ovalid || m_axis_tready;
    assign w_next_phase = (r_vel > 0) ? r_phase + 1'b1 : r_phase - 1'b1;
    assign w_div_start  = w_accept && (w_req == REQ_UPDATE) && (w_mag != '0);

    hssrd_div #(
        .NUMERATOR (INTERVAL_NUMERATOR)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_den   (w_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    // request sequencer and motor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= '0;
            r_vel     <= '0;
            r_last_ts <= '0;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (w_req)
                            REQ_UPDATE: begin
                                if (w_mag != '0) begin
                                    r_state <= S_DIV;
                                end else begin
                                    r_vel <= w_ramped;
                                end
                            end
                            REQ_BURST: begin
                                r_cnt <= w_burst_n;
                                if (w_burst_n != '0) begin
                                    r_state <= S_BURST;
                                end
                            end
                            REQ_LOAD: begin
                                r_vel <= (w_speed < SPEED_MIN) ? SPEED_MIN : w_speed;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_stat.done) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (!w_due) begin
                        r_vel   <= w_ramped;
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_ovalid  <= 1'b1;
                        r_phase   <= w_next_phase;
                        r_last_ts <= r_ts;
                        r_vel     <= w_ramped;
                        r_state   <= S_IDLE;
                    end
                end
                S_BURST: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_phase  <= w_next_phase;
                        r_cnt    <= r_cnt - 1'b1;
                        if (r_cnt == CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers: timestamp capture and output word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ts      <= w_ts;
            r_elapsed <= w_ts - r_last_ts;
        end
        if (((r_state == S_CMP) && w_due && w_out_free) ||
            ((r_state == S_BURST) && w_out_free)) begin
            r_ocoil  <= coil_of(r_phase);
            r_ophase <= r_phase;
            r_olast  <= (r_state == S_CMP) || (r_cnt == CNT_W'(1));
        end
    end

    // acceleration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cfg_valid) begin
            r_acc <= i_cfg_data;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE) && !w_div_stat.busy;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_ophase, r_ocoil};
    assign m_axis_tlast  = r_olast;

endmodule

>>> bench/halfstep_stepper_ramp_driver_tb.sv
`timescale 1ns / 100ps

module halfstep_stepper_ramp_driver_tb;
    import hssrd_pkg::*;

    localparam int MAX_BURST     = 16;
    localparam int INTERVAL_NUM  = 256000;
    localparam int SETTLE_CYCLES = 40;
    // run time limit, several times the slowest correct run
    localparam int RUN_LIMIT_NS  = 4_000_000;

    // selector value the block ignores
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // half-step coil table, phases 0 to 7
    localparam t_coil HALFSTEP_COILS [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

    typedef struct {
        t_coil  coil;
        t_phase phase;
        logic   last;
    } coil_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;   // timestamp_us[31:0], step_count[36:32],
                                      // speed_value[52:37], zero fill
    logic [1:0]  s_axis_tuser = '0;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // coil_pattern[3:0], phase_index[6:4], zero fill
    logic        m_axis_tlast;        // last_of_run
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [SPEED_W-1:0] i_cfg_data = '0;

    // predictor state
    t_phase                    step_phase = '0;
    logic signed [SPEED_W-1:0] ramp_speed = '0;
    logic signed [SPEED_W-1:0] ramp_accel = '0;
    logic [TS_W-1:0]           last_step_us = '0;

    coil_word_t pattern_q[$];
    coil_word_t want;

    // stimulus control and bookkeeping
    int          tx_max_gap = 0;
    int          rx_max_gap = 0;
    int          rx_hold_cycles = 0;
    logic [31:0] clock_us = '0;
    int          mismatch_count = 0;
    int          words_checked = 0;
    int          req_counts [4] = '{0, 0, 0, 0};
    int          accel_writes = 0;

    halfstep_stepper_ramp_driver #(
        .MAX_BURST         (MAX_BURST),
        .INTERVAL_NUMERATOR(INTERVAL_NUM)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("halfstep_stepper_ramp_driver_tb failed");
        $finish;
    end

    // queue the pattern of the current phase, then move the phase
    function automatic void push_step(input logic last);
        pattern_q.push_back('{HALFSTEP_COILS[step_phase], step_phase, last});
        if (ramp_speed > 0)
            step_phase = step_phase + 3'd1;
        else
            step_phase = step_phase - 3'd1;
    endfunction

    function automatic int clamp_speed(input int v);
        if (v > int'(SPEED_MAX))
            return int'(SPEED_MAX);
        if (v < int'(SPEED_MIN))
            return int'(SPEED_MIN);
        return v;
    endfunction

    function automatic int speed_interval();
        int mag;
        mag = int'(ramp_speed);
        if (mag < 0)
            mag = -mag;
        return INTERVAL_NUM / (mag + 1);
    endfunction

    // expected coil words for one accepted request
    function automatic void predict_request(input logic [1:0] kind, input logic [31:0] ts,
                                            input logic [4:0] cnt,
                                            input logic signed [15:0] spd);
        int n;
        logic [31:0] elapsed;
        case (kind)
            REQ_UPDATE: begin
                if (ramp_speed != 0) begin
                    elapsed = ts - last_step_us;
                    if (elapsed >= speed_interval()) begin
                        push_step(1'b1);
                        last_step_us = ts;
                    end
                end
                ramp_speed = 16'(clamp_speed(int'(ramp_speed) + int'(ramp_accel)));
            end
            REQ_BURST: begin
                n = int'(cnt);
                if (n > MAX_BURST)
                    n = MAX_BURST;
                for (int i = 0; i < n; i++)
                    push_step(i == n - 1);
            end
            REQ_LOAD: begin
                ramp_speed = 16'(clamp_speed(int'(spd)));
            end
            default: ;
        endcase
    endfunction

    // offer one request word, wait for the handshake, then idle a random while
    task automatic send_request(input logic [1:0] kind, input logic [31:0] ts,
                                input logic [4:0] cnt, input logic signed [15:0] spd);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, spd, cnt, ts};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_request(kind, ts, cnt, spd);
        req_counts[kind]++;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // drop valid, let every expected word arrive, then let the block settle
    task automatic wait_for_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pattern_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_accel(input logic signed [15:0] value);
        wait_for_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        ramp_accel = value;
        accel_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver: random hold-off before each word, long hold when asked
    initial begin
        int gap;
        @(negedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                gap = $urandom_range(0, rx_max_gap);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // compare each accepted coil word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            words_checked++;
            if (pattern_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected coil word: coil %h phase %0d last %0b",
                             m_axis_tdata[3:0], m_axis_tdata[6:4], m_axis_tlast);
            end else begin
                want = pattern_q.pop_front();
                if (m_axis_tdata[3:0] !== want.coil || m_axis_tdata[6:4] !== want.phase ||
                    m_axis_tlast !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("coil word mismatch: expected coil %h phase %0d last %0b",
                               want.coil, want.phase, want.last);
                        $display(", got coil %h phase %0d last %0b",
                                 m_axis_tdata[3:0], m_axis_tdata[6:4], m_axis_tlast);
                    end
                end
            end
        end
    end

    // zero speed right after reset, empty and single-pattern bursts, ignored selector
    task automatic test_idle_after_reset();
        tx_max_gap = 18;
        rx_max_gap = 18;
        send_request(REQ_UPDATE, 32'd0, 5'd0, 16'sd0);
        send_request(REQ_BURST, 32'hFFFF_FFFF, 5'd0, 16'sh7FFF);
        send_request(REQ_BURST, 32'd0, 5'd1, 16'sd0);
        send_request(REQ_UNUSED, $urandom, 5'h1F, 16'shFFFF);
    endtask

    // longest legal burst and counts past the clamp
    task automatic test_burst_lengths();
        send_request(REQ_BURST, 32'd0, 5'd16, 16'sd0);
        send_request(REQ_BURST, 32'd0, 5'd17, 16'sd0);
        send_request(REQ_BURST, 32'd0, 5'd31, 16'sd0);
    endtask

    // load extremes, the most negative value gets clamped, bursts show direction
    task automatic test_speed_loads();
        send_request(REQ_LOAD, 32'd0, 5'd0, -16'sd32768);
        send_request(REQ_BURST, 32'd0, 5'd2, 16'sd0);
        send_request(REQ_LOAD, 32'd0, 5'd0, 16'sd32767);
        send_request(REQ_BURST, 32'd0, 5'd3, 16'sd0);
    endtask

    // step due exactly at the interval, longest and shortest interval, time wrap
    task automatic test_step_timing();
        send_request(REQ_LOAD, 32'd0, 5'd0, 16'sd1);
        send_request(REQ_UPDATE, 32'd127999, 5'd0, 16'sd0);
        send_request(REQ_UPDATE, 32'd128000, 5'd0, 16'sd0);
        send_request(REQ_LOAD, 32'd0, 5'd0, 16'sd32767);
        send_request(REQ_UPDATE, 32'd128006, 5'd0, 16'sd0);
        send_request(REQ_UPDATE, 32'd128007, 5'd0, 16'sd0);
        send_request(REQ_UPDATE, 32'hFFFF_FFFF, 5'd0, 16'sd0);
        send_request(REQ_UPDATE, 32'd6, 5'd0, 16'sd0);
        clock_us = 32'd6;
    endtask

    // speed ramps into both limits
    task automatic test_speed_saturation();
        write_accel(16'sd32767);
        send_request(REQ_LOAD, 32'd0, 5'd0, 16'sd32767);
        send_request(REQ_UPDATE, 32'd200000, 5'd0, 16'sd0);
        write_accel(-16'sd32768);
        send_request(REQ_LOAD, 32'd0, 5'd0, -16'sd32767);
        send_request(REQ_UPDATE, 32'd200001, 5'd0, 16'sd0);
        send_request(REQ_LOAD, 32'd0, 5'd0, 16'sd100);
        send_request(REQ_UPDATE, 32'd400000, 5'd0, 16'sd0);
        clock_us = 32'd400000;
    endtask

    // receiver holds off for a long stretch while full bursts keep coming
    task automatic test_output_backpressure();
        write_accel(16'sd0);
        tx_max_gap = 0;
        rx_hold_cycles = 300;
        repeat (6) send_request(REQ_BURST, $urandom, 5'd16, 16'(int'($urandom)));
    endtask

    // mostly well-paced updates, bursts and loads with random content, some noise
    task automatic run_random_phase(input int n_items, input logic signed [15:0] accel,
                                    input int tx_gap, input int rx_gap);
        int r;
        logic [1:0]         kind;
        logic [31:0]        ts;
        logic [4:0]         cnt;
        logic signed [15:0] spd;
        write_accel(accel);
        tx_max_gap = tx_gap;
        rx_max_gap = rx_gap;
        repeat (n_items) begin
            r   = $urandom_range(0, 99);
            ts  = $urandom;
            cnt = 5'($urandom);
            spd = 16'($urandom);
            if (r < 45) begin
                kind = REQ_UPDATE;
                // advance time around the current step interval most of the time
                if ($urandom_range(0, 9) != 0) begin
                    if (ramp_speed == 0)
                        ts = clock_us + $urandom_range(0, 1000);
                    else
                        ts = clock_us + $urandom_range(0, 2 * speed_interval());
                end
                clock_us = ts;
            end else if (r < 70) begin
                kind = REQ_BURST;
                if ($urandom_range(0, 7) != 0)
                    cnt = 5'($urandom_range(0, MAX_BURST));
            end else if (r < 95) begin
                kind = REQ_LOAD;
                if ($urandom_range(0, 1) != 0)
                    spd = 16'($urandom_range(0, 600) - 300);
            end else begin
                kind = REQ_UNUSED;
            end
            send_request(kind, ts, cnt, spd);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_after_reset();
        test_burst_lengths();
        test_speed_loads();
        test_step_timing();
        test_speed_saturation();
        test_output_backpressure();
        run_random_phase(40, 16'sd0, 18, 18);
        run_random_phase(40, 16'sd25, 0, 0);
        run_random_phase(40, -16'sd32768, 18, 6);
        run_random_phase(40, 16'sd32767, 6, 18);
        run_random_phase(40, 16'($urandom), 18, 18);

        wait_for_idle();
        $display("requests: %0d update, %0d burst, %0d load, %0d ignored; %0d accel writes",
                 req_counts[REQ_UPDATE], req_counts[REQ_BURST], req_counts[REQ_LOAD],
                 req_counts[REQ_UNUSED], accel_writes);
        $display("coil words checked: %0d, mismatches: %0d", words_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("halfstep_stepper_ramp_driver_tb passed");
        end else begin
            $display("halfstep_stepper_ramp_driver_tb failed");
        end
        $finish;
    end

endmodule
